[rtl/mbe_pkg.sv]
// ---------------------------------------------------------------------------
// mbe_pkg - shared types and constants
// Fixed-point formats, datapath widths and the controller/datapath
// command and status structs for the escape-time unit.
// ---------------------------------------------------------------------------
package mbe_pkg;

  // Q4.28 fixed point
  localparam int FRAC_BITS = 28;
  localparam int ITER_BITS = 16;

  localparam int C_W   = 31;              // input point parts, signed
  localparam int Z_W   = 32;              // z after one update stays below 6.0
  localparam int M_W   = Z_W - 1;         // magnitude of z
  localparam int P_W   = 2 * M_W;         // exact product
  localparam int S_W   = P_W + 1;         // exact sum of squares
  localparam int MAG_W = 31;              // output magnitude
  localparam int RAD_W = 64;              // square root radicand
  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W = ROOT_W + 3;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int STEP_W = $clog2(SQRT_STEPS);

  typedef struct packed {
    logic load;       // take a new point, clear z and the iteration count
    logic mult;       // register the three products of z
    logic update;     // z <= z*z + c, count one iteration
    logic finish;     // latch the result count, start the square root
    logic sqrt_step;  // one root bit
    logic out_load;   // move the result into the output register
  } cmd_t;

  typedef struct packed {
    logic escaped;    // |z|^2 >= 4
    logic at_limit;   // iteration count has reached max_iter
  } status_t;

endpackage

[rtl/mbe_ifs.sv]
// ---------------------------------------------------------------------------
// mbe_ifs - valid/ready channels
// Point channel into the block and result channel out of it.
// ---------------------------------------------------------------------------
interface mbe_point_if;
  logic                             valid;
  logic                             ready;
  logic signed [mbe_pkg::C_W-1:0]   c_re;
  logic signed [mbe_pkg::C_W-1:0]   c_im;

  modport source (output valid, c_re, c_im, input ready);
  modport sink   (input valid, c_re, c_im, output ready);
endinterface

interface mbe_result_if;
  logic                             valid;
  logic                             ready;
  logic [mbe_pkg::ITER_BITS-1:0]    iter_count;
  logic [mbe_pkg::MAG_W-1:0]        magnitude;

  modport source (output valid, iter_count, magnitude, input ready);
  modport sink   (input valid, iter_count, magnitude, output ready);
endinterface

[rtl/mbe_datapath.sv]
// ---------------------------------------------------------------------------
// mbe_datapath - iteration and square-root datapath
// Holds c, z, the product registers, the iteration counter, the limit
// register, a one-bit-per-cycle integer square root and the output payload.
// ---------------------------------------------------------------------------
module mbe_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [mbe_pkg::ITER_BITS-1:0]       cfg_wdata,
  input  logic signed [mbe_pkg::C_W-1:0]      c_re_in,
  input  logic signed [mbe_pkg::C_W-1:0]      c_im_in,
  input  mbe_pkg::cmd_t                       cmd,
  output mbe_pkg::status_t                    status,
  output logic [mbe_pkg::ITER_BITS-1:0]       iter_count,
  output logic [mbe_pkg::MAG_W-1:0]           magnitude
);

  localparam int W_W = mbe_pkg::P_W - mbe_pkg::FRAC_BITS + 2;   // update arithmetic
  localparam logic signed [mbe_pkg::C_W-1:0] C_LIM =
    mbe_pkg::C_W'(64'sd2 <<< mbe_pkg::FRAC_BITS);
  localparam logic signed [mbe_pkg::C_W-1:0] C_NLIM = -C_LIM;
  localparam logic [mbe_pkg::S_W-1:0] FOUR =
    mbe_pkg::S_W'(1) << (2 * mbe_pkg::FRAC_BITS + 2);
  localparam logic [mbe_pkg::MAG_W-1:0] MAG_SAT = '1;

  function automatic logic signed [mbe_pkg::C_W-1:0] clamp(
    input logic signed [mbe_pkg::C_W-1:0] v
  );
    logic signed [mbe_pkg::C_W-1:0] r;
    r = v;
    if (v > C_LIM) r = C_LIM;
    if (v < C_NLIM) r = C_NLIM;
    return r;
  endfunction

  logic [mbe_pkg::ITER_BITS-1:0]      max_iter;
  logic signed [mbe_pkg::C_W-1:0]     c_re;
  logic signed [mbe_pkg::C_W-1:0]     c_im;
  logic signed [mbe_pkg::Z_W-1:0]     z_re;
  logic signed [mbe_pkg::Z_W-1:0]     z_im;
  logic [mbe_pkg::P_W-1:0]            p_rr;
  logic [mbe_pkg::P_W-1:0]            p_ii;
  logic [mbe_pkg::P_W-1:0]            p_ri;
  logic [mbe_pkg::ITER_BITS-1:0]      iter;
  logic [mbe_pkg::ITER_BITS-1:0]      count_hold;
  logic [mbe_pkg::RAD_W-1:0]          rad;
  logic [mbe_pkg::REM_W-1:0]          rem;
  logic [mbe_pkg::ROOT_W-1:0]         root;

  logic [mbe_pkg::M_W-1:0]            mag_re;
  logic [mbe_pkg::M_W-1:0]            mag_im;
  logic [mbe_pkg::S_W-1:0]            sum_sq;
  logic signed [W_W-1:0]              re_next;
  logic signed [W_W-1:0]              im_next;
  logic signed [W_W-1:0]              cross_term;
  logic [mbe_pkg::REM_W-1:0]          rem_sh;
  logic [mbe_pkg::REM_W-1:0]          trial;

  // operands: |z| fits M_W bits since z stays below 6.0
  always_comb begin
    mag_re = z_re[mbe_pkg::Z_W-1] ? mbe_pkg::M_W'(-z_re) : mbe_pkg::M_W'(z_re);
    mag_im = z_im[mbe_pkg::Z_W-1] ? mbe_pkg::M_W'(-z_im) : mbe_pkg::M_W'(z_im);
  end

  // escape test and z update from the registered products
  always_comb begin
    sum_sq  = mbe_pkg::S_W'(p_rr) + mbe_pkg::S_W'(p_ii);
    re_next = $signed(W_W'(p_rr[mbe_pkg::P_W-1:mbe_pkg::FRAC_BITS]))
            - $signed(W_W'(p_ii[mbe_pkg::P_W-1:mbe_pkg::FRAC_BITS]))
            + W_W'(c_re);
    cross_term = $signed(W_W'(p_ri[mbe_pkg::P_W-1:mbe_pkg::FRAC_BITS-1]));
    im_next = ((z_re[mbe_pkg::Z_W-1] ^ z_im[mbe_pkg::Z_W-1]) ? -cross_term : cross_term)
            + W_W'(c_im);
    status.escaped  = (sum_sq >= FOUR);
    status.at_limit = (iter == max_iter);
  end

  // restoring square root step
  always_comb begin
    rem_sh = {rem[mbe_pkg::REM_W-3:0], rad[mbe_pkg::RAD_W-1 -: 2]};
    trial  = mbe_pkg::REM_W'({root, 2'b01});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_iter <= mbe_pkg::ITER_BITS'(256);
    end else if (cfg_we) begin
      max_iter <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      c_re <= clamp(c_re_in);
      c_im <= clamp(c_im_in);
      z_re <= '0;
      z_im <= '0;
      iter <= '0;
    end else if (cmd.update) begin
      z_re <= mbe_pkg::Z_W'(re_next);
      z_im <= mbe_pkg::Z_W'(im_next);
      iter <= iter + 1'b1;
    end
    if (cmd.mult) begin
      p_rr <= mag_re * mag_re;
      p_ii <= mag_im * mag_im;
      p_ri <= mag_re * mag_im;
    end
    if (cmd.finish) begin
      count_hold <= status.escaped ? iter - 1'b1 : max_iter;
      rad        <= mbe_pkg::RAD_W'(sum_sq);
      rem        <= '0;
      root       <= '0;
    end else if (cmd.sqrt_step) begin
      rad <= {rad[mbe_pkg::RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[mbe_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[mbe_pkg::ROOT_W-2:0], 1'b0};
      end
    end
    if (cmd.out_load) begin
      iter_count <= count_hold;
      magnitude  <= (root > mbe_pkg::ROOT_W'(MAG_SAT)) ? MAG_SAT
                                                       : mbe_pkg::MAG_W'(root);
    end
  end

endmodule

[rtl/mbe_ctrl.sv]
// ---------------------------------------------------------------------------
// mbe_ctrl - sequencer
// Walks each point through multiply / evaluate iterations, the square
// root and the output hand-off; owns the channel handshakes.
// ---------------------------------------------------------------------------
module mbe_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  point_valid,
  output logic                  point_ready,
  output logic                  result_valid,
  input  logic                  result_ready,
  input  mbe_pkg::status_t      status,
  output mbe_pkg::cmd_t         cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_EVAL = 3'd2;
  localparam logic [2:0] S_SQRT = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]                   state;
  logic [2:0]                   state_next;
  logic [mbe_pkg::STEP_W-1:0]   step;

  always_comb begin
    cmd         = '0;
    state_next  = state;
    point_ready = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (point_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mult   = 1'b1;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        if (status.escaped || status.at_limit) begin
          cmd.finish = 1'b1;
          state_next = S_SQRT;
        end else begin
          cmd.update = 1'b1;
          state_next = S_MUL;
        end
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (step == mbe_pkg::STEP_W'(mbe_pkg::SQRT_STEPS - 1)) state_next = S_DONE;
      end
      S_DONE: begin
        if (!result_valid || result_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      step         <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) step <= '0;
      else if (cmd.sqrt_step) step <= step + 1'b1;
      if (cmd.out_load) result_valid <= 1'b1;
      else if (result_ready) result_valid <= 1'b0;
    end
  end

endmodule

[rtl/mandelbrot_escape_time.sv]
// ---------------------------------------------------------------------------
// mandelbrot_escape_time - escape-time unit for one point
// Usage:
//   point  : valid/ready sink, c_re and c_im in signed Q3.28; each part is
//            saturated to +/-2.0 on entry.
//   result : valid/ready source, iter_count (escape index, or max_iter when
//            the point stays bounded) and magnitude (|z| at exit, unsigned
//            Q3.28, saturated to the 31-bit range).
//   cfg_we / cfg_wdata : writes max_iter (reset value 256); write only while
//            the block is idle.
// Timing: one point at a time. Each iteration passes through the z loop
//   (product register, then add and escape test), and the root is a
//   32-bit restoring square root, one bit a cycle.
// The result sits in an output register; point.ready rises again as soon as
//   it is loaded, so the next point runs while the result waits. If the
//   receiver still stalls when that next point is done, the block holds in
//   its final state until the register empties.
// Reset (synchronous, active high) drops result.valid, returns the
//   sequencer to idle and sets max_iter to 256.
// ---------------------------------------------------------------------------
module mandelbrot_escape_time (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [mbe_pkg::ITER_BITS-1:0]   cfg_wdata,
  mbe_point_if.sink                       point,
  mbe_result_if.source                    result
);

  mbe_pkg::cmd_t     cmd;
  mbe_pkg::status_t  status;

  // sequencer: handshakes and step ordering
  mbe_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .point_valid  (point.valid),
    .point_ready  (point.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .status       (status),
    .cmd          (cmd)
  );

  // datapath: z loop, root, limit register and output payload
  mbe_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .c_re_in    (point.c_re),
    .c_im_in    (point.c_im),
    .cmd        (cmd),
    .status     (status),
    .iter_count (result.iter_count),
    .magnitude  (result.magnitude)
  );

endmodule
